/* rtl/core/mf_pkg.sv */
// shared types and constants for the 3x3 median filter
package mf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COORD_W     = 11;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 8;
    localparam int WIN_SIZE    = 9;
    localparam int WIN_MID     = 4;

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [COORD_W-1:0] coord_t;

    // 3x3 window, entry k*3+j is row k (0 = oldest line), column j (2 = newest)
    typedef logic [WIN_SIZE-1:0][PIXEL_W-1:0] window_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 8'd0,
        REG_FRAME_HEIGHT = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        pixel_t pixel;
        logic   drain;
    } in_beat_t;

    typedef struct packed {
        pixel_t filtered;
        coord_t out_row;
        coord_t out_col;
        logic   frame_end;
    } out_beat_t;

endpackage

/* rtl/core/mf_median9.sv */
// median of nine pixels through a fixed compare-exchange network
module mf_median9 (
    input  mf_pkg::window_t win,
    output mf_pkg::pixel_t  med
);

    // order entries a and b so that the smaller sits at a
    function automatic mf_pkg::window_t cx(mf_pkg::window_t x, int a, int b);
        mf_pkg::window_t y;
        y = x;
        if (x[a] > x[b]) begin
            y[a] = x[b];
            y[b] = x[a];
        end
        return y;
    endfunction

    mf_pkg::window_t v;

    always_comb begin
        v = win;
        // sort the three rows
        v = cx(v, 1, 2);
        v = cx(v, 4, 5);
        v = cx(v, 7, 8);
        v = cx(v, 0, 1);
        v = cx(v, 3, 4);
        v = cx(v, 6, 7);
        v = cx(v, 1, 2);
        v = cx(v, 4, 5);
        v = cx(v, 7, 8);
        // max of mins, min of maxes, median of medians
        v = cx(v, 0, 3);
        v = cx(v, 5, 8);
        v = cx(v, 4, 7);
        v = cx(v, 3, 6);
        v = cx(v, 1, 4);
        v = cx(v, 2, 5);
        v = cx(v, 4, 7);
        v = cx(v, 4, 2);
        v = cx(v, 6, 4);
        v = cx(v, 4, 2);
    end

    assign med = v[mf_pkg::WIN_MID];

endmodule

/* rtl/core/median_filter_3x3.sv */
// streaming 3x3 median filter top level with line stores and window
//
//  channel | ports                              | carries
//  --------+------------------------------------+-----------------------------
//  s_      | s_valid s_ready s_data             | pixel, drain per beat
//  m_      | m_valid m_ready m_data             | filtered, out_row, out_col,
//          |                                    | frame_end per beat
//  cfg_    | cfg_valid cfg_ready cfg_index      | frame_width (0),
//          | cfg_data                           | frame_height (1)
//
//  one input beat per clock unless m_ back-pressure stalls; a beat that yields
//  a result passes the line store read and middle-stage registers at
//  acceptance, then the window plus median network into the result register
//  results trail pixels by one line plus one pixel; frame_width+1 drain beats
//  flush the end of a frame
//  synchronous active-low reset clears position, window and valids; the line
//  stores are not cleared and need no sweep
//  m_ready low holds the result register; the middle stage still takes a beat,
//  and s_ready drops only when both are occupied
module median_filter_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  mf_pkg::in_beat_t                    s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output mf_pkg::out_beat_t                   m_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // column index, clamped width, row counter (runs to height+1 in the drain)
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    localparam logic [WW-1:0] W_RST = WW'((mf_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                                          MAX_WIDTH : mf_pkg::FRAME_WIDTH_RST);
    localparam logic [RW-1:0] H_RST = RW'((mf_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                                          MAX_HEIGHT : mf_pkg::FRAME_HEIGHT_RST);

    function automatic logic [WW-1:0] clamp_w(logic [mf_pkg::CFG_DATA_W-1:0] v);
        if (v < 3) begin
            return WW'(3);
        end else if (v > MAX_WIDTH) begin
            return WW'(MAX_WIDTH);
        end
        return WW'(v);
    endfunction

    function automatic logic [RW-1:0] clamp_h(logic [mf_pkg::CFG_DATA_W-1:0] v);
        if (v < 3) begin
            return RW'(3);
        end else if (v > MAX_HEIGHT) begin
            return RW'(MAX_HEIGHT);
        end
        return RW'(v);
    endfunction

    // ---------------------------------------------------------------
    // configuration, stored already clamped
    // ---------------------------------------------------------------
    logic [WW-1:0] w_reg;
    logic [RW-1:0] h_reg;
    logic [WW-1:0] w_m1, w_m2;
    logic [RW-1:0] h_m1, h_m2;
    logic          cfg_hit;

    assign cfg_ready = 1'b1;
    assign w_m1 = w_reg - WW'(1);
    assign w_m2 = w_reg - WW'(2);
    assign h_m1 = h_reg - RW'(1);
    assign h_m2 = h_reg - RW'(2);

    always_comb begin
        case (cfg_index)
            mf_pkg::REG_FRAME_WIDTH:  cfg_hit = cfg_valid;
            mf_pkg::REG_FRAME_HEIGHT: cfg_hit = cfg_valid;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= W_RST;
            h_reg <= H_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mf_pkg::REG_FRAME_WIDTH:  w_reg <= clamp_w(cfg_data);
                mf_pkg::REG_FRAME_HEIGHT: h_reg <= clamp_h(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input stage: position counters and result coordinates
    // ---------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic          accept;
    logic          pix_phase;
    logic          ignore;
    logic          take;
    logic          have;
    logic [RW-1:0] ro;
    logic [CW-1:0] co;
    logic          interior;
    logic          fend;

    assign accept    = s_valid && s_ready;
    assign pix_phase = row_reg < h_reg;
    // drain beats before the frame is complete do nothing
    assign ignore    = pix_phase && s_data.drain;
    assign take      = accept && !ignore;

    always_comb begin
        if (col_reg == '0) begin
            // first column closes the line before last
            have = row_reg >= RW'(2);
            ro   = row_reg - RW'(2);
            co   = CW'(w_m1);
        end else begin
            have = row_reg >= RW'(1);
            ro   = row_reg - RW'(1);
            co   = col_reg - CW'(1);
        end
        interior = (ro != '0) && (ro <= h_m2) && (co != '0) && (WW'(co) <= w_m2);
        fend     = (ro == h_m1) && (WW'(co) == w_m1);

        if (have && fend) begin
            col_next = '0;
            row_next = '0;
        end else if (WW'(col_reg) == w_m1) begin
            col_next = '0;
            row_next = row_reg + RW'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (take) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // line stores: a holds the previous line, b the one before
    // ---------------------------------------------------------------
    mf_pkg::pixel_t line_a [MAX_WIDTH];
    mf_pkg::pixel_t line_b [MAX_WIDTH];
    mf_pkg::pixel_t rd_a_reg, rd_b_reg;

    logic          mem_en;
    logic          s1_valid_reg, s1_pix_reg, s1_have_reg, s1_interior_reg, s1_fend_reg;
    logic [CW-1:0] s1_wcol_reg;
    mf_pkg::pixel_t s1_pixel_reg;
    mf_pkg::coord_t s1_row_reg, s1_col_reg;
    logic          s1_move;
    logic          out_free;

    assign mem_en = take && pix_phase;

    // read-first: old line a goes to the window, new pixel replaces it
    always_ff @(posedge aclk) begin
        if (mem_en) begin
            rd_a_reg        <= line_a[col_reg];
            line_a[col_reg] <= s_data.pixel;
        end
    end

    // line b takes the old line a entry once it leaves the middle stage
    always_ff @(posedge aclk) begin
        if (mem_en) begin
            rd_b_reg <= line_b[col_reg];
        end
        if (s1_move && s1_pix_reg) begin
            line_b[s1_wcol_reg] <= rd_a_reg;
        end
    end

    // ---------------------------------------------------------------
    // middle stage: window shift and median
    // ---------------------------------------------------------------
    assign out_free = !m_valid || m_ready;
    // beats without a result never wait on the output
    assign s1_move  = s1_valid_reg && (!s1_have_reg || out_free);
    assign s_ready  = !s1_valid_reg || s1_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (take) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_pix_reg      <= pix_phase;
            s1_have_reg     <= have;
            s1_interior_reg <= interior;
            s1_fend_reg     <= fend;
            s1_wcol_reg     <= col_reg;
            s1_pixel_reg    <= s_data.pixel;
            s1_row_reg      <= mf_pkg::coord_t'(ro);
            s1_col_reg      <= mf_pkg::coord_t'(co);
        end
    end

    mf_pkg::window_t win_reg, win_next;
    mf_pkg::pixel_t  med;

    always_comb begin
        win_next = win_reg;
        if (s1_pix_reg) begin
            for (int k = 0; k < 3; k++) begin
                win_next[k*3 + 0] = win_reg[k*3 + 1];
                win_next[k*3 + 1] = win_reg[k*3 + 2];
            end
            win_next[2] = rd_b_reg;
            win_next[5] = rd_a_reg;
            win_next[8] = s1_pixel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_move) begin
            win_reg <= win_next;
        end
    end

    mf_median9 u_median (
        .win (win_next),
        .med (med)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic              m_valid_reg;
    mf_pkg::out_beat_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move && s1_have_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s1_have_reg) begin
            // border pixels come out as zero
            m_data_reg.filtered  <= s1_interior_reg ? med : '0;
            m_data_reg.out_row   <= s1_row_reg;
            m_data_reg.out_col   <= s1_col_reg;
            m_data_reg.frame_end <= s1_fend_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(col_reg) < w_reg)
        else $error("column counter past line width");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= h_reg + RW'(1))
        else $error("row counter past drain line");

    a_fend_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |->
            (m_data.out_row == mf_pkg::coord_t'(h_m1)) &&
            (m_data.out_col == mf_pkg::coord_t'(w_m1)))
        else $error("frame end not on last pixel");

    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_data.out_col == '0) || (m_data.out_row == '0)) |->
            m_data.filtered == '0)
        else $error("border pixel not zero");

    a_early_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ignore && !cfg_hit |=> $stable(col_reg) && $stable(row_reg))
        else $error("early drain beat moved position");

endmodule
